/* src/sacs_pkg.sv */
// ----------------------------------------------------------------------------
// sacs_pkg
// Shared types and constants for the set-associative cache tag store model.
// ----------------------------------------------------------------------------
`default_nettype none

package sacs_pkg;

    // parameter defaults
    localparam int DEF_MAX_SETS   = 256;
    localparam int DEF_MAX_WAYS   = 8;
    localparam int DEF_ADDR_WIDTH = 64;

    // fixed field widths
    localparam int FIELD_ADDR_W = 64;
    localparam int SIZE_W       = 7;
    localparam int TALLY_W      = 32;
    localparam int STAMP_W      = 32;
    localparam int MAX_ACCESS   = 64;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 2'd3;

    localparam logic [3:0] RST_SET_BITS   = 4'd0;
    localparam logic [3:0] RST_WAYS       = 4'd1;
    localparam logic [3:0] RST_BLOCK_BITS = 4'd4;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    typedef struct packed {
        logic [FIELD_ADDR_W-1:0] address;
        logic [SIZE_W-1:0]       access_size;
    } t_item;

    typedef struct packed {
        logic               was_hit;
        logic               was_evicted;
        logic [TALLY_W-1:0] hits_total;
        logic [TALLY_W-1:0] misses_total;
        logic [TALLY_W-1:0] evictions_total;
        logic               last_line;
    } t_result;

    // sequencer to way scan unit
    typedef struct packed {
        logic step;
        logic first;
    } t_scan_ctrl;

    // way scan unit to sequencer
    typedef struct packed {
        logic hit;
        logic inv_found;
    } t_scan_stat;

endpackage

`default_nettype wire

/* src/set_assoc_cache_sim.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_sim
// Set-associative cache tag store with FIFO or LRU replacement and
// saturating hit, miss and eviction totals.
// ----------------------------------------------------------------------------
// Each access is split into one line access per cache line touched.
// A line access runs through address split, set row read, a step per way in
// use through the shared compare unit, and row write-back (none on a FIFO hit).
// Its result word shows in the cycle after the write-back. An access holds
// busy until its last line is written back; a new start is taken as its last
// word shows. After reset a clearing pass over all MAX_SETS sets zeroes the
// tag store; busy is high meanwhile. Results cannot be stalled by the receiver.
`default_nettype none

module set_assoc_cache_sim #(
    parameter int MAX_SETS   = sacs_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS   = sacs_pkg::DEF_MAX_WAYS,
    parameter int ADDR_WIDTH = sacs_pkg::DEF_ADDR_WIDTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire sacs_pkg::t_item                  i_item,
    output logic                                  o_strobe,
    output sacs_pkg::t_result                     o_result,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [sacs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sacs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int MAX_SB  = $clog2(MAX_SETS + 1) - 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_W   = $clog2(MAX_WAYS + 1);
    localparam int STAMP_W = sacs_pkg::STAMP_W;
    localparam int TALLY_W = sacs_pkg::TALLY_W;
    localparam int WB      = 1 + ADDR_WIDTH + STAMP_W;
    localparam int ROW_W   = MAX_WAYS * WB;
    localparam int LINES_W = 6;
    localparam int SHIFT_W = 5;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_ADDR   = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_UPDATE = 3'd5;

    function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] v);
        return (v == {TALLY_W{1'b1}}) ? v : v + TALLY_W'(1);
    endfunction

    // configuration
    logic [3:0] r_set_bits;
    logic [3:0] r_ways;
    logic [3:0] r_block_bits;
    logic       r_policy;

    // sequencer and datapath
    logic [2:0]              r_state;
    logic [SET_W-1:0]        r_clr_set;
    logic [ADDR_WIDTH-1:0]   r_cur_addr;
    logic [LINES_W-1:0]      r_lines_left;
    logic [SET_W-1:0]        r_set;
    logic [ADDR_WIDTH-1:0]   r_tag;
    logic [WAY_W-1:0]        r_way;
    logic [STAMP_W-1:0]      r_clock;
    logic [TALLY_W-1:0]      r_hits;
    logic [TALLY_W-1:0]      r_misses;
    logic [TALLY_W-1:0]      r_evicts;
    logic                    r_strobe;
    sacs_pkg::t_result       r_result;

    // derived values
    logic [3:0]              sb_eff;
    logic [4:0]              k5;
    logic [CNT_W-1:0]        k_eff;
    logic                    last_way;
    logic [ADDR_WIDTH-1:0]   line_mask;
    logic [ADDR_WIDTH-1:0]   line_step;
    logic [ADDR_WIDTH-1:0]   next_addr;
    logic [SET_W:0]          set_span;
    logic [SET_W-1:0]        set_mask;
    logic [SHIFT_W-1:0]      tag_shift;
    logic [ADDR_WIDTH-1:0]   in_addr;
    logic [sacs_pkg::SIZE_W-1:0] size_eff;
    logic [15:0]             span;
    logic [LINES_W-1:0]      lines_m1;

    // memory and scan unit
    logic                    ram_we;
    logic [SET_W-1:0]        ram_waddr;
    logic [ROW_W-1:0]        ram_wdata;
    logic [ROW_W-1:0]        ram_rdata;
    logic [ROW_W-1:0]        n_row;
    sacs_pkg::t_scan_ctrl    scan_ctrl;
    sacs_pkg::t_scan_stat    scan_stat;
    logic [WAY_W-1:0]        hit_way;
    logic [WAY_W-1:0]        inv_way;
    logic [WAY_W-1:0]        best_way;
    logic [WAY_W-1:0]        victim;
    logic                    evict;
    logic [STAMP_W-1:0]      n_clock;

    always_comb begin
        sb_eff    = (r_set_bits > 4'(MAX_SB)) ? 4'(MAX_SB) : r_set_bits;
        if (r_ways == 4'd0) begin
            k5 = 5'd1;
        end else if ({1'b0, r_ways} > 5'(MAX_WAYS)) begin
            k5 = 5'(MAX_WAYS);
        end else begin
            k5 = {1'b0, r_ways};
        end
        k_eff     = CNT_W'(k5);
        last_way  = (r_way == WAY_W'(k_eff - CNT_W'(1)));

        line_step = ADDR_WIDTH'(1) << r_block_bits;
        line_mask = line_step - ADDR_WIDTH'(1);
        next_addr = (r_cur_addr & ~line_mask) + line_step;

        set_span  = (SET_W + 1)'(1) << sb_eff;
        set_mask  = SET_W'(set_span - (SET_W + 1)'(1));
        tag_shift = SHIFT_W'(r_block_bits) + SHIFT_W'(sb_eff);

        // number of lines touched by the incoming access, less one
        in_addr   = i_item.address[ADDR_WIDTH-1:0];
        if (i_item.access_size == '0) begin
            size_eff = sacs_pkg::SIZE_W'(1);
        end else if (i_item.access_size > sacs_pkg::SIZE_W'(sacs_pkg::MAX_ACCESS)) begin
            size_eff = sacs_pkg::SIZE_W'(sacs_pkg::MAX_ACCESS);
        end else begin
            size_eff = i_item.access_size;
        end
        span      = (in_addr[15:0] & line_mask[15:0]) + 16'(size_eff) - 16'd1;
        lines_m1  = LINES_W'(span >> r_block_bits);
    end

    // replacement choice and row update
    always_comb begin
        victim  = scan_stat.inv_found ? inv_way : best_way;
        evict   = !scan_stat.hit && !scan_stat.inv_found;
        n_clock = r_clock + STAMP_W'(1);
        n_row   = ram_rdata;
        if (scan_stat.hit) begin
            n_row[hit_way*WB +: STAMP_W] = n_clock;
        end else begin
            n_row[victim*WB +: WB] = {1'b1, r_tag, n_clock};
        end
    end

    always_comb begin
        scan_ctrl.step  = (r_state == ST_SCAN);
        scan_ctrl.first = (r_way == '0);
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_set;
            ram_wdata = '0;
        end else begin
            ram_we    = (r_state == ST_UPDATE)
                        && (!scan_stat.hit || r_policy == sacs_pkg::POLICY_LRU);
            ram_waddr = r_set;
            ram_wdata = n_row;
        end
    end

    sacs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_set),
        .o_rdata (ram_rdata)
    );

    sacs_scan #(
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (scan_ctrl),
        .i_way      (r_way),
        .i_row      (ram_rdata),
        .i_tag      (r_tag),
        .o_stat     (scan_stat),
        .o_hit_way  (hit_way),
        .o_inv_way  (inv_way),
        .o_best_way (best_way)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= sacs_pkg::RST_SET_BITS;
            r_ways       <= sacs_pkg::RST_WAYS;
            r_block_bits <= sacs_pkg::RST_BLOCK_BITS;
            r_policy     <= sacs_pkg::POLICY_FIFO;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sacs_pkg::CFG_SET_BITS:   r_set_bits   <= i_cfg_data;
                sacs_pkg::CFG_WAYS:       r_ways       <= i_cfg_data;
                sacs_pkg::CFG_BLOCK_BITS: r_block_bits <= i_cfg_data;
                sacs_pkg::CFG_POLICY:     r_policy     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_set <= '0;
            r_way     <= '0;
            r_clock   <= '0;
            r_hits    <= '0;
            r_misses  <= '0;
            r_evicts  <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe <= (r_state == ST_UPDATE);
            unique case (r_state)
                ST_CLEAR: begin
                    if (r_clr_set == SET_W'(MAX_SETS - 1)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_clr_set <= r_clr_set + SET_W'(1);
                    end
                end
                ST_IDLE: begin
                    if (start) begin
                        r_state <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    r_state <= ST_READ;
                end
                ST_READ: begin
                    r_way   <= '0;
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (last_way) begin
                        r_state <= ST_UPDATE;
                    end else begin
                        r_way <= r_way + WAY_W'(1);
                    end
                end
                ST_UPDATE: begin
                    r_clock  <= n_clock;
                    if (scan_stat.hit) begin
                        r_hits <= sat_inc(r_hits);
                    end else begin
                        r_misses <= sat_inc(r_misses);
                    end
                    if (evict) begin
                        r_evicts <= sat_inc(r_evicts);
                    end
                    r_state <= (r_lines_left == '0) ? ST_IDLE : ST_ADDR;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_cur_addr   <= in_addr;
            r_lines_left <= lines_m1;
        end
        if (r_state == ST_ADDR) begin
            r_set <= SET_W'(r_cur_addr >> r_block_bits) & set_mask;
            r_tag <= r_cur_addr >> tag_shift;
        end
        if (r_state == ST_UPDATE) begin
            r_result.was_hit         <= scan_stat.hit;
            r_result.was_evicted     <= evict;
            r_result.hits_total      <= scan_stat.hit ? sat_inc(r_hits) : r_hits;
            r_result.misses_total    <= scan_stat.hit ? r_misses : sat_inc(r_misses);
            r_result.evictions_total <= evict ? sat_inc(r_evicts) : r_evicts;
            r_result.last_line       <= (r_lines_left == '0);
            if (r_lines_left != '0) begin
                r_lines_left <= r_lines_left - LINES_W'(1);
                r_cur_addr   <= next_addr;
            end
        end
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;
    assign o_cfg_ready = 1'b1;

    a_strobe_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state == ST_UPDATE))
        else $error("result word without a write-back cycle");

    a_last_frees_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_result.last_line) |-> !busy)
        else $error("busy after last line word");

    a_evict_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_result.was_evicted) |-> !r_result.was_hit)
        else $error("eviction reported on a hit");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (CNT_W'(r_way) < k_eff))
        else $error("way scan beyond ways in use");

endmodule

`default_nettype wire

/* src/sacs_ram.sv */
// ----------------------------------------------------------------------------
// sacs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sacs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]                              i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/sacs_scan.sv */
// ----------------------------------------------------------------------------
// sacs_scan
// Way scan unit: one tag compare and one stamp compare, stepped over the
// ways of a set row, keeping first hit, first invalid way and oldest stamp.
// ----------------------------------------------------------------------------
`default_nettype none

module sacs_scan #(
    parameter int MAX_WAYS   = sacs_pkg::DEF_MAX_WAYS,
    parameter int ADDR_WIDTH = sacs_pkg::DEF_ADDR_WIDTH
) (
    input  wire logic                                                    i_clk,
    input  wire logic                                                    i_rst_n,
    input  wire sacs_pkg::t_scan_ctrl                                    i_ctrl,
    input  wire logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0]      i_way,
    input  wire logic [MAX_WAYS*(1+ADDR_WIDTH+sacs_pkg::STAMP_W)-1:0]    i_row,
    input  wire logic [ADDR_WIDTH-1:0]                                   i_tag,
    output sacs_pkg::t_scan_stat                                         o_stat,
    output logic      [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0]      o_hit_way,
    output logic      [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0]      o_inv_way,
    output logic      [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0]      o_best_way
);

    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WB    = 1 + ADDR_WIDTH + sacs_pkg::STAMP_W;

    logic [WB-1:0]                 sel;
    logic                          sel_valid;
    logic [ADDR_WIDTH-1:0]         sel_tag;
    logic [sacs_pkg::STAMP_W-1:0]  sel_stamp;
    logic                          match;
    logic                          older;

    logic                          r_hit;
    logic                          r_inv;
    logic [WAY_W-1:0]              r_hit_way;
    logic [WAY_W-1:0]              r_inv_way;
    logic [WAY_W-1:0]              r_best_way;
    logic [sacs_pkg::STAMP_W-1:0]  r_best;

    always_comb begin
        sel       = i_row[i_way*WB +: WB];
        sel_valid = sel[WB-1];
        sel_tag   = sel[WB-2 -: ADDR_WIDTH];
        sel_stamp = sel[sacs_pkg::STAMP_W-1:0];
        match     = sel_valid && (sel_tag == i_tag);
        older     = sel_stamp < r_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
            r_inv <= 1'b0;
        end else if (i_ctrl.step) begin
            if (i_ctrl.first) begin
                r_hit <= match;
                r_inv <= !sel_valid;
            end else begin
                if (!r_hit && match) begin
                    r_hit <= 1'b1;
                end
                if (!r_inv && !sel_valid) begin
                    r_inv <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.step) begin
            if (i_ctrl.first) begin
                r_hit_way  <= i_way;
                r_inv_way  <= i_way;
                r_best_way <= i_way;
                r_best     <= sel_stamp;
            end else begin
                if (!r_hit && match) begin
                    r_hit_way <= i_way;
                end
                if (!r_inv && !sel_valid) begin
                    r_inv_way <= i_way;
                end
                // strict compare keeps the lowest way on equal stamps
                if (older) begin
                    r_best_way <= i_way;
                    r_best     <= sel_stamp;
                end
            end
        end
    end

    assign o_stat.hit       = r_hit;
    assign o_stat.inv_found = r_inv;
    assign o_hit_way        = r_hit_way;
    assign o_inv_way        = r_inv_way;
    assign o_best_way       = r_best_way;

endmodule

`default_nettype wire
